// ===== sv/ashk_pkg.sv =====
// Types, constants and microcode program for the AABB spatial hash key unit.
package ashk_pkg;

    localparam int COORD_W = 32;
    localparam int MAG_W   = 31;
    localparam int DCNT_W  = 5;
    localparam int KEY_W   = 64;
    localparam int PROD_W  = 60;
    localparam int PC_W    = 4;

    localparam logic [MAG_W-1:0] CELL_SIZE_RESET = 31'd256;

    localparam logic signed [27:0] PRIME_X = 28'sd73856093;
    localparam logic signed [27:0] PRIME_Y = 28'sd19349663;
    localparam logic signed [27:0] PRIME_Z = 28'sd83492791;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_START,
        OP_STORE,
        OP_INIT,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        W_NONE,
        W_IN,
        W_DIV,
        W_EMIT
    } wait_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z,
        AX_NONE
    } axis_t;

    typedef struct packed {
        op_t              op;
        axis_t            axis;
        wait_t            waitc;
        logic             jump;
        logic [PC_W-1:0]  target;
    } uword_t;

    localparam logic [PC_W-1:0] PC_LOAD = 4'd0;

    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        begin
            unique case (pc)
                4'd0:    w = '{OP_LOAD,      AX_NONE, W_IN,   1'b0, PC_LOAD};
                4'd1:    w = '{OP_DIV_START, AX_X,    W_NONE, 1'b0, PC_LOAD};
                4'd2:    w = '{OP_NOP,       AX_X,    W_DIV,  1'b0, PC_LOAD};
                4'd3:    w = '{OP_STORE,     AX_X,    W_NONE, 1'b0, PC_LOAD};
                4'd4:    w = '{OP_DIV_START, AX_Y,    W_NONE, 1'b0, PC_LOAD};
                4'd5:    w = '{OP_NOP,       AX_Y,    W_DIV,  1'b0, PC_LOAD};
                4'd6:    w = '{OP_STORE,     AX_Y,    W_NONE, 1'b0, PC_LOAD};
                4'd7:    w = '{OP_DIV_START, AX_Z,    W_NONE, 1'b0, PC_LOAD};
                4'd8:    w = '{OP_NOP,       AX_Z,    W_DIV,  1'b0, PC_LOAD};
                4'd9:    w = '{OP_STORE,     AX_Z,    W_NONE, 1'b0, PC_LOAD};
                4'd10:   w = '{OP_INIT,      AX_NONE, W_NONE, 1'b0, PC_LOAD};
                4'd11:   w = '{OP_EMIT,      AX_NONE, W_EMIT, 1'b1, PC_LOAD};
                default: w = '{OP_NOP,       AX_NONE, W_NONE, 1'b1, PC_LOAD};
            endcase
            return w;
        end
    endfunction

endpackage

// ===== sv/ashk_div.sv =====
// Serial restoring floor divider: signed coordinate over positive cell size.
module ashk_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ashk_pkg::COORD_W-1:0] dividend,
    input  logic        [ashk_pkg::MAG_W-1:0]   divisor,
    output logic                                busy,
    output logic signed [ashk_pkg::COORD_W-1:0] quotient
);

    logic [ashk_pkg::DCNT_W-1:0]  cnt_reg, cnt_next;
    logic [ashk_pkg::MAG_W-1:0]   rem_reg, rem_next;
    logic [ashk_pkg::MAG_W-1:0]   quo_reg, quo_next;
    logic                         neg_reg;
    logic [ashk_pkg::MAG_W:0]     shifted;
    logic [ashk_pkg::MAG_W:0]     trial;
    logic                         fits;
    logic [ashk_pkg::MAG_W-1:0]   mag;

    assign mag     = dividend[ashk_pkg::COORD_W-1] ? ~dividend[ashk_pkg::MAG_W-1:0]
                                                   : dividend[ashk_pkg::MAG_W-1:0];
    assign shifted = {rem_reg, quo_reg[ashk_pkg::MAG_W-1]};
    assign trial   = shifted - {1'b0, divisor};
    assign fits    = shifted >= {1'b0, divisor};
    assign busy    = cnt_reg != '0;

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = ashk_pkg::DCNT_W'(ashk_pkg::MAG_W);
            rem_next = '0;
            quo_next = mag;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? trial[ashk_pkg::MAG_W-1:0] : shifted[ashk_pkg::MAG_W-1:0];
            quo_next = {quo_reg[ashk_pkg::MAG_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            neg_reg <= dividend[ashk_pkg::COORD_W-1];
        end
    end

    assign quotient = neg_reg ? ~{1'b0, quo_reg} : {1'b0, quo_reg};

endmodule

// ===== sv/aabb_spatial_hash_keys_unit.sv =====
// Top level: microcoded AABB to spatial hash grid cell key generator.
// Sequence: a box is taken in the load step, then per axis a start, a wait on the two
// 31-step dividers and a store, then init and emit of cells into the output register.
// A box gives N emitted cells (1 to MAX_SPAN^3); the three axis divisions each run on two
// 31-step dividers in parallel; one cell per cycle while out_ready does not stall the output.
// Reset: sequencer to the load step, output empty, cell size to 256.
module aabb_spatial_hash_keys_unit
#(
    parameter int MAX_SPAN = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic        [ashk_pkg::MAG_W-1:0]   cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ashk_pkg::COORD_W-1:0] corner_a_x,
    input  logic signed [ashk_pkg::COORD_W-1:0] corner_a_y,
    input  logic signed [ashk_pkg::COORD_W-1:0] corner_a_z,
    input  logic signed [ashk_pkg::COORD_W-1:0] corner_b_x,
    input  logic signed [ashk_pkg::COORD_W-1:0] corner_b_y,
    input  logic signed [ashk_pkg::COORD_W-1:0] corner_b_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic        [ashk_pkg::KEY_W-1:0]   cell_key,
    output logic signed [ashk_pkg::COORD_W-1:0] cell_x,
    output logic signed [ashk_pkg::COORD_W-1:0] cell_y,
    output logic signed [ashk_pkg::COORD_W-1:0] cell_z,
    output logic                                last_cell,
    output logic                                span_clipped
);

    localparam int CW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SPAN - 1);

    logic [ashk_pkg::PC_W-1:0]           pc_reg, pc_next;
    ashk_pkg::uword_t                    uw;
    logic                                stay;
    logic [ashk_pkg::MAG_W-1:0]          cell_size_reg;
    logic [ashk_pkg::MAG_W-1:0]          cs_eff;

    logic signed [ashk_pkg::COORD_W-1:0] ca_reg [3];
    logic signed [ashk_pkg::COORD_W-1:0] cb_reg [3];
    logic signed [ashk_pkg::COORD_W-1:0] lo_reg [3];
    logic [CW-1:0]                       cnt_reg [3];
    logic [CW-1:0]                       off_reg [3];
    logic signed [ashk_pkg::COORD_W-1:0] cur_reg [3];
    logic                                clip_reg;
    logic [1:0]                          ax;

    logic signed [ashk_pkg::COORD_W-1:0] sel_a, sel_b, mn, mx;
    logic signed [ashk_pkg::COORD_W-1:0] q_lo, q_hi;
    logic                                div_busy_lo, div_busy_hi;
    logic                                div_start;
    logic [ashk_pkg::COORD_W:0]          diff;
    logic                                diff_clip;

    logic                                out_valid_reg;
    logic [ashk_pkg::KEY_W-1:0]          key_reg;
    logic signed [ashk_pkg::COORD_W-1:0] ox_reg, oy_reg, oz_reg;
    logic                                last_reg, clipo_reg;
    logic                                slot_free, emit_fire, emit_last;
    logic signed [ashk_pkg::PROD_W-1:0]  prod_x, prod_y, prod_z;
    logic [ashk_pkg::KEY_W-1:0]          key_next;

    assign uw        = ashk_pkg::ucode_rom(pc_reg);
    assign ax        = uw.axis;
    assign in_ready  = uw.op == ashk_pkg::OP_LOAD;
    assign cs_eff    = (cell_size_reg == '0) ? ashk_pkg::MAG_W'(1) : cell_size_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign emit_last = (off_reg[0] == cnt_reg[0]) && (off_reg[1] == cnt_reg[1])
                       && (off_reg[2] == cnt_reg[2]);
    assign emit_fire = (uw.op == ashk_pkg::OP_EMIT) && slot_free;
    assign div_start = uw.op == ashk_pkg::OP_DIV_START;

    always_comb
    begin
        unique case (uw.waitc)
            ashk_pkg::W_IN:   stay = !in_valid;
            ashk_pkg::W_DIV:  stay = div_busy_lo;
            ashk_pkg::W_EMIT: stay = !(slot_free && emit_last);
            default:          stay = 1'b0;
        endcase
        if (stay)
        begin
            pc_next = pc_reg;
        end
        else if (uw.jump)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ashk_pkg::PC_LOAD;
            out_valid_reg <= 1'b0;
            cell_size_reg <= ashk_pkg::CELL_SIZE_RESET;
        end
        else
        begin
            pc_reg <= pc_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                cell_size_reg <= cfg_wdata;
            end
        end
    end

    // Order the corners of the selected axis
    always_comb
    begin
        sel_a = ca_reg[0];
        sel_b = cb_reg[0];
        if (ax != ashk_pkg::AX_NONE)
        begin
            sel_a = ca_reg[ax];
            sel_b = cb_reg[ax];
        end
        mn = (sel_a < sel_b) ? sel_a : sel_b;
        mx = (sel_a < sel_b) ? sel_b : sel_a;
    end

    ashk_div u_div_lo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mn),
        .divisor  (cs_eff),
        .busy     (div_busy_lo),
        .quotient (q_lo)
    );

    ashk_div u_div_hi
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mx),
        .divisor  (cs_eff),
        .busy     (div_busy_hi),
        .quotient (q_hi)
    );

    assign diff      = {q_hi[ashk_pkg::COORD_W-1], q_hi} - {q_lo[ashk_pkg::COORD_W-1], q_lo};
    assign diff_clip = diff > (ashk_pkg::COORD_W+1)'(MAX_SPAN - 1);

    assign prod_x   = cur_reg[0] * ashk_pkg::PRIME_X;
    assign prod_y   = cur_reg[1] * ashk_pkg::PRIME_Y;
    assign prod_z   = cur_reg[2] * ashk_pkg::PRIME_Z;
    assign key_next = ashk_pkg::KEY_W'(prod_x) ^ ashk_pkg::KEY_W'(prod_y)
                      ^ ashk_pkg::KEY_W'(prod_z);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ca_reg[0] <= corner_a_x;
            ca_reg[1] <= corner_a_y;
            ca_reg[2] <= corner_a_z;
            cb_reg[0] <= corner_b_x;
            cb_reg[1] <= corner_b_y;
            cb_reg[2] <= corner_b_z;
            clip_reg  <= 1'b0;
        end
        if (uw.op == ashk_pkg::OP_STORE && ax != ashk_pkg::AX_NONE)
        begin
            lo_reg[ax]  <= q_lo;
            cnt_reg[ax] <= diff_clip ? CNT_MAX : diff[CW-1:0];
            if (diff_clip)
            begin
                clip_reg <= 1'b1;
            end
        end
        if (uw.op == ashk_pkg::OP_INIT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                off_reg[i] <= '0;
                cur_reg[i] <= lo_reg[i];
            end
        end
        if (emit_fire)
        begin
            key_reg   <= key_next;
            ox_reg    <= cur_reg[0];
            oy_reg    <= cur_reg[1];
            oz_reg    <= cur_reg[2];
            last_reg  <= emit_last;
            clipo_reg <= clip_reg;
            // advance z innermost, then y, then x
            if (off_reg[2] != cnt_reg[2])
            begin
                off_reg[2] <= off_reg[2] + 1'b1;
                cur_reg[2] <= cur_reg[2] + 32'sd1;
            end
            else
            begin
                off_reg[2] <= '0;
                cur_reg[2] <= lo_reg[2];
                if (off_reg[1] != cnt_reg[1])
                begin
                    off_reg[1] <= off_reg[1] + 1'b1;
                    cur_reg[1] <= cur_reg[1] + 32'sd1;
                end
                else
                begin
                    off_reg[1] <= '0;
                    cur_reg[1] <= lo_reg[1];
                    off_reg[0] <= off_reg[0] + 1'b1;
                    cur_reg[0] <= cur_reg[0] + 32'sd1;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_key     = key_reg;
    assign cell_x       = ox_reg;
    assign cell_y       = oy_reg;
    assign cell_z       = oz_reg;
    assign last_cell    = last_reg;
    assign span_clipped = clipo_reg;

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_lo == div_busy_hi)
        else $error("floor dividers out of step");

    a_load_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_busy_lo)
        else $error("box accepted while a division runs");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_last) |=> (pc_reg == ashk_pkg::PC_LOAD))
        else $error("sequencer did not return to load after last cell");

    a_off_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == ashk_pkg::OP_EMIT) |-> (off_reg[0] <= cnt_reg[0] && off_reg[1] <= cnt_reg[1]
                                          && off_reg[2] <= cnt_reg[2]))
        else $error("cell offset beyond span");

endmodule
